[sv/trigram_document_frequency_index_top_defines.svh]
// Assertion macros for the trigram index checker
`ifndef TRIGRAM_DOCUMENT_FREQUENCY_INDEX_TOP_DEFINES_SVH
`define TRIGRAM_DOCUMENT_FREQUENCY_INDEX_TOP_DEFINES_SVH

// same-cycle implication, sampled on clk, off during reset
`define TDFI_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define TDFI_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[sv/tdfi_pkg.sv]
// Shared types, constants and index function for the trigram index
`default_nettype none
package tdfi_pkg;

  localparam int ALPHA        = 26;
  localparam int TRI_DEPTH    = ALPHA * ALPHA * ALPHA;
  localparam int ADDR_W       = $clog2(TRI_DEPTH);
  localparam int COUNT_BITS   = 20;
  localparam int WORD_ID_BITS = 20;
  localparam int LETTER_W     = 5;
  localparam int ACTION_W     = 2;
  localparam int OUT_W        = 20;

  localparam logic [ACTION_W-1:0] ACT_LETTER = 2'd0;
  localparam logic [ACTION_W-1:0] ACT_END    = 2'd1;
  localparam logic [ACTION_W-1:0] ACT_QUERY  = 2'd2;

  localparam logic [COUNT_BITS-1:0]   COUNT_MAX = '1;
  localparam logic [WORD_ID_BITS-1:0] ID_MAX    = '1;

  typedef struct packed {
    logic [ACTION_W-1:0] action;
    logic [LETTER_W-1:0] letter;
    logic [LETTER_W-1:0] query_first;
    logic [LETTER_W-1:0] query_second;
    logic [LETTER_W-1:0] query_third;
  } tdfi_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] word_hits;
    logic [OUT_W-1:0] words_total;
    logic             capacity_exceeded;
  } tdfi_out_t;

  typedef struct packed {
    logic [WORD_ID_BITS-1:0] stamp;
    logic [COUNT_BITS-1:0]   count;
  } tdfi_entry_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    tdfi_entry_t       wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } tdfi_mem_req_t;

  function automatic logic [ADDR_W-1:0] tri_index(
    input logic [LETTER_W-1:0] a,
    input logic [LETTER_W-1:0] b,
    input logic [LETTER_W-1:0] c
  );
    logic [ADDR_W-1:0] ab;
    ab = ADDR_W'(a) * ADDR_W'(ALPHA) + ADDR_W'(b);
    return ab * ADDR_W'(ALPHA) + ADDR_W'(c);
  endfunction

endpackage
`default_nettype wire

[sv/tdfi_ram.sv]
// Trigram memory: word stamp and count per trigram, registered read
`default_nettype none
module tdfi_ram (
  input  wire logic                   clk,
  input  wire tdfi_pkg::tdfi_mem_req_t mem_req,
  output      tdfi_pkg::tdfi_entry_t  rdata
);

  tdfi_pkg::tdfi_entry_t mem [tdfi_pkg::TRI_DEPTH];
  tdfi_pkg::tdfi_entry_t rdata_r;

  always_ff @(posedge clk) begin
    if (mem_req.we) begin
      mem[mem_req.waddr] <= mem_req.wdata;
    end
    if (mem_req.re) begin
      rdata_r <= mem[mem_req.raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

[sv/tdfi_ctrl.sv]
// Sequencer: memory clear, letter read-modify-write, word close and query
`default_nettype none
module tdfi_ctrl (
  input  wire logic                    clk,
  input  wire logic                    rst_n,
  input  wire logic                    in_valid,
  input  wire tdfi_pkg::tdfi_in_t      in_data,
  output      logic                    in_stall,
  input  wire logic                    out_busy,
  output      logic                    res_load,
  output      tdfi_pkg::tdfi_out_t     res_data,
  output      tdfi_pkg::tdfi_mem_req_t mem_req,
  input  wire tdfi_pkg::tdfi_entry_t   mem_rdata
);

  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RMW   = 2'd2;
  localparam logic [1:0] ST_QRES  = 2'd3;

  logic [1:0]                       state_r, state_nxt;
  logic [tdfi_pkg::ADDR_W-1:0]      clr_addr_r, clr_addr_nxt;
  logic [tdfi_pkg::ADDR_W-1:0]      addr_r, addr_nxt;
  logic [tdfi_pkg::WORD_ID_BITS-1:0] word_id_r, word_id_nxt;
  logic [tdfi_pkg::LETTER_W-1:0]    older_r, older_nxt;
  logic [tdfi_pkg::LETTER_W-1:0]    newer_r, newer_nxt;
  logic [1:0]                       nlet_r, nlet_nxt;
  logic [tdfi_pkg::COUNT_BITS-1:0]  loaded_r, loaded_nxt;
  logic                             dropped_r, dropped_nxt;
  logic                             qok_r, qok_nxt;

  logic                        letter_ok;
  logic                        query_ok;
  logic [tdfi_pkg::ADDR_W-1:0] letter_idx;
  logic [tdfi_pkg::ADDR_W-1:0] query_idx;

  assign letter_ok  = in_data.letter < tdfi_pkg::LETTER_W'(tdfi_pkg::ALPHA);
  assign query_ok   = (in_data.query_first  < tdfi_pkg::LETTER_W'(tdfi_pkg::ALPHA)) &&
                      (in_data.query_second < tdfi_pkg::LETTER_W'(tdfi_pkg::ALPHA)) &&
                      (in_data.query_third  < tdfi_pkg::LETTER_W'(tdfi_pkg::ALPHA));
  assign letter_idx = tdfi_pkg::tri_index(older_r, newer_r, in_data.letter);
  assign query_idx  = tdfi_pkg::tri_index(in_data.query_first, in_data.query_second,
                                          in_data.query_third);

  assign in_stall = (state_r != ST_IDLE);

  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    addr_nxt     = addr_r;
    word_id_nxt  = word_id_r;
    older_nxt    = older_r;
    newer_nxt    = newer_r;
    nlet_nxt     = nlet_r;
    loaded_nxt   = loaded_r;
    dropped_nxt  = dropped_r;
    qok_nxt      = qok_r;
    mem_req      = '0;
    res_load     = 1'b0;
    unique case (state_r)
      ST_CLEAR: begin
        mem_req.we    = 1'b1;
        mem_req.waddr = clr_addr_r;
        clr_addr_nxt  = clr_addr_r + 1'b1;
        if (clr_addr_r == tdfi_pkg::ADDR_W'(tdfi_pkg::TRI_DEPTH - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_data.action)
            tdfi_pkg::ACT_LETTER: begin
              if (letter_ok) begin
                if ((nlet_r >= 2'd2) && (word_id_r != '0)) begin
                  mem_req.re    = 1'b1;
                  mem_req.raddr = letter_idx;
                  addr_nxt      = letter_idx;
                  state_nxt     = ST_RMW;
                end
                older_nxt = newer_r;
                newer_nxt = in_data.letter;
                if (nlet_r != 2'd3) begin
                  nlet_nxt = nlet_r + 2'd1;
                end
              end
            end
            tdfi_pkg::ACT_END: begin
              if (nlet_r == 2'd3) begin
                if (word_id_r == '0) begin
                  dropped_nxt = 1'b1;
                end else begin
                  if (loaded_r != tdfi_pkg::COUNT_MAX) begin
                    loaded_nxt = loaded_r + 1'b1;
                  end
                  word_id_nxt = (word_id_r == tdfi_pkg::ID_MAX) ? '0 : word_id_r + 1'b1;
                end
              end
              nlet_nxt  = 2'd0;
              older_nxt = '0;
              newer_nxt = '0;
            end
            tdfi_pkg::ACT_QUERY: begin
              qok_nxt       = query_ok;
              mem_req.re    = query_ok;
              mem_req.raddr = query_idx;
              state_nxt     = ST_QRES;
            end
            default: begin
            end
          endcase
        end
      end
      ST_RMW: begin
        if (mem_rdata.stamp != word_id_r) begin
          mem_req.we          = 1'b1;
          mem_req.waddr       = addr_r;
          mem_req.wdata.stamp = word_id_r;
          mem_req.wdata.count = (mem_rdata.count == tdfi_pkg::COUNT_MAX) ?
                                mem_rdata.count : mem_rdata.count + 1'b1;
        end
        state_nxt = ST_IDLE;
      end
      ST_QRES: begin
        if (!out_busy) begin
          res_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    res_data.word_hits         = qok_r ? tdfi_pkg::OUT_W'(mem_rdata.count) : '0;
    res_data.words_total       = tdfi_pkg::OUT_W'(loaded_r);
    res_data.capacity_exceeded = dropped_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      word_id_r  <= tdfi_pkg::WORD_ID_BITS'(1);
      older_r    <= '0;
      newer_r    <= '0;
      nlet_r     <= 2'd0;
      loaded_r   <= '0;
      dropped_r  <= 1'b0;
      qok_r      <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      word_id_r  <= word_id_nxt;
      older_r    <= older_nxt;
      newer_r    <= newer_nxt;
      nlet_r     <= nlet_nxt;
      loaded_r   <= loaded_nxt;
      dropped_r  <= dropped_nxt;
      qok_r      <= qok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
  end

endmodule
`default_nettype wire

[sv/trigram_document_frequency_index_top.sv]
// Top level of the letter-trigram document-frequency index
//
//   channel | ports                        | carries
//   --------+------------------------------+-----------------------------------
//   input   | in_valid, in_stall, in_data  | letter, end of word, query request
//   result  | out_valid, out_stall, out_data | hits, words loaded, drop flag
//
// A letter that completes a trigram reads the trigram memory, then writes the entry back
// if the current word has not counted it yet. Other letters and end-of-word requests
// finish in the idle state; a query reads the memory, then waits for the result
// register to empty. After reset in_stall is set while memory clears one entry per cycle.
// A waiting result does not block letters or end-of-word requests.
`default_nettype none
module trigram_document_frequency_index_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output      logic                in_stall,
  input  wire tdfi_pkg::tdfi_in_t  in_data,
  output      logic                out_valid,
  input  wire logic                out_stall,
  output      tdfi_pkg::tdfi_out_t out_data
);

  tdfi_pkg::tdfi_mem_req_t mem_req;
  tdfi_pkg::tdfi_entry_t   mem_rdata;
  tdfi_pkg::tdfi_out_t     res_data;
  tdfi_pkg::tdfi_out_t     out_data_r;
  logic                    res_load;
  logic                    out_busy;
  logic                    out_valid_r;

  assign out_busy = out_valid_r && out_stall;

  tdfi_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_data   (in_data),
    .in_stall  (in_stall),
    .out_busy  (out_busy),
    .res_load  (res_load),
    .res_data  (res_data),
    .mem_req   (mem_req),
    .mem_rdata (mem_rdata)
  );

  tdfi_ram u_ram (
    .clk     (clk),
    .mem_req (mem_req),
    .rdata   (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_data_r <= res_data;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule
`default_nettype wire

[sv/tdfi_chk.sv]
// Port-level checker for the trigram index, bound to the top level
`default_nettype none
`include "trigram_document_frequency_index_top_defines.svh"
module tdfi_chk (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                in_stall,
  input wire logic                out_valid,
  input wire logic                out_stall,
  input wire tdfi_pkg::tdfi_out_t out_data
);

  logic                       out_acc;
  logic [tdfi_pkg::OUT_W-1:0] last_total_r;
  logic                       flag_seen_r;

  assign out_acc = out_valid && !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_total_r <= '0;
      flag_seen_r  <= 1'b0;
    end else if (out_acc) begin
      last_total_r <= out_data.words_total;
      flag_seen_r  <= flag_seen_r || out_data.capacity_exceeded;
    end
  end

  `TDFI_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `TDFI_ASSERT_IMP(a_total_mono, out_acc, out_data.words_total >= last_total_r, "words total fell")
  `TDFI_ASSERT_IMP(a_flag_sticky, out_acc && flag_seen_r, out_data.capacity_exceeded, "drop flag cleared")
  `TDFI_ASSERT_IMP(a_clear_stall, $past(!rst_n), in_stall && !out_valid, "request taken during clear")

endmodule

bind trigram_document_frequency_index_top tdfi_chk u_chk (.*);
`default_nettype wire
